[rtl/framed_speed_command_parser_assert.svh]
// Assertion macros for the framed speed command parser.
// Used by the top level; needs a clock and an active-low reset passed in.
`ifndef FRAMED_SPEED_COMMAND_PARSER_ASSERT_SVH
`define FRAMED_SPEED_COMMAND_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FSCP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FSCP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/fscp_pkg.sv]
// Shared constants for the framed speed command parser.
// No dependencies; used by the top level.
`default_nettype none

package fscp_pkg;

    localparam int FRAME_DEPTH = 32;
    localparam int FIELD_CHARS = 8;

    localparam int IDX_W  = $clog2(FRAME_DEPTH);
    localparam int FILL_W = $clog2(FRAME_DEPTH + 1);
    localparam int CNT_W  = $clog2(FIELD_CHARS + 1);

    localparam int MAG_CAP   = 1000;
    localparam int MAG_W     = $clog2(MAG_CAP + 1);
    localparam int ACC_W     = MAG_W + 4;
    localparam int SPEED_MAX = 100;
    localparam int MIN_FRAME = 6;

    localparam logic [7:0] CH_START = 8'h3C;
    localparam logic [7:0] CH_END   = 8'h3E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_LEFT  = 8'h4C;
    localparam logic [7:0] CH_RIGHT = 8'h52;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

endpackage

`default_nettype wire

[rtl/fscp_if.sv]
// Valid/ready channel interfaces for received bytes and parsed results.
// Depends on fscp_pkg for nothing but sits after it in compile order.
`default_nettype none

interface fscp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fscp_out_if;
    logic              valid;
    logic              ready;
    logic              frame_ok;
    logic signed [7:0] spd_left;
    logic signed [7:0] spd_right;

    modport source (output valid, output frame_ok, output spd_left,
                    output spd_right, input ready);
    modport sink   (input valid, input frame_ok, input spd_left,
                    input spd_right, output ready);
endinterface

`default_nettype wire

[rtl/framed_speed_command_parser.sv]
// Framed speed command parser: byte in, speed pair out on each frame end.
// Depends on fscp_pkg, fscp_if.sv and framed_speed_command_parser_assert.svh.
//
// Usage:
//   i_rx carries one received byte per beat. A '<' opens a frame; bytes
//   outside a frame are dropped. On '>' the stored frame "<[L]l,[R]r>" is
//   scanned and one result beat is sent on o_res: frame_ok and two signed
//   speeds, zero when the frame is rejected.
// Timing:
//   A byte that does not close a frame is taken while the parser is idle. A
//   closing '>' keeps i_rx.ready low while the frame is scanned, because
//   the frame memory has one registered read port and each stored byte goes
//   through a read state and an evaluate state of the shared digit unit.
//   A frame shorter than six bytes skips the scan and is rejected. After the
//   scan, the result is loaded into the output register that drives o_res.
// Reset and stall:
//   i_rst_n is synchronous, active low; it empties the frame and the output
//   register. The frame memory itself is not cleared. While o_res is
//   stalled, new bytes are still accepted; a frame end waits until the
//   output register is free.
`default_nettype none
`include "framed_speed_command_parser_assert.svh"

module framed_speed_command_parser (
    input  wire         i_clk,
    input  wire         i_rst_n,
    fscp_in_if.sink     i_rx,
    fscp_out_if.source  o_res
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD,
        ST_EV,
        ST_FIN
    } t_state;

    typedef enum logic [1:0] {
        CP_BLANK,
        CP_DIGIT,
        CP_DONE
    } t_cphase;

    logic [7:0] mem [fscp_pkg::FRAME_DEPTH];
    logic [7:0] r_rdata;

    t_state                        r_state, n_state;
    logic [fscp_pkg::FILL_W-1:0]   r_fill, n_fill;
    logic [fscp_pkg::IDX_W-1:0]    r_idx, n_idx;
    logic [fscp_pkg::IDX_W-1:0]    r_lastpos, n_lastpos;
    logic                          r_right, n_right;
    logic                          r_first, n_first;
    t_cphase                       r_cphase, n_cphase;
    logic                          r_neg, n_neg;
    logic [fscp_pkg::MAG_W-1:0]    r_mag, n_mag;
    logic [fscp_pkg::CNT_W-1:0]    r_cnt, n_cnt;
    logic                          r_lneg, n_lneg;
    logic [fscp_pkg::MAG_W-1:0]    r_lmag, n_lmag;
    logic [fscp_pkg::CNT_W-1:0]    r_lcnt, n_lcnt;
    logic                          r_out_valid, n_out_valid;
    logic                          r_out_ok, n_out_ok;
    logic [7:0]                    r_out_left, n_out_left;
    logic [7:0]                    r_out_right, n_out_right;

    logic                          w_en;
    logic [fscp_pkg::IDX_W-1:0]    w_addr;
    logic                          accept;

    // Shared digit unit signals.
    logic                          is_digit, is_blank;
    logic [fscp_pkg::ACC_W-1:0]    acc;
    logic [fscp_pkg::ACC_W-1:0]    mag_ext;
    logic                          feed;
    logic                          ok;
    logic [7:0]                    lmag8, rmag8;

    assign i_rx.ready      = (r_state == ST_IDLE);
    assign accept          = i_rx.valid && (r_state == ST_IDLE);
    assign o_res.valid     = r_out_valid;
    assign o_res.frame_ok  = r_out_ok;
    assign o_res.spd_left  = $signed(r_out_left);
    assign o_res.spd_right = $signed(r_out_right);

    assign is_digit = (r_rdata >= fscp_pkg::CH_ZERO) && (r_rdata <= fscp_pkg::CH_NINE);
    assign is_blank = (r_rdata == fscp_pkg::CH_SPACE) ||
                      ((r_rdata >= fscp_pkg::CH_TAB) && (r_rdata <= fscp_pkg::CH_CR));
    assign mag_ext  = fscp_pkg::ACC_W'(r_mag);
    assign acc      = (mag_ext << 3) + (mag_ext << 1) +
                      fscp_pkg::ACC_W'(r_rdata[3:0]);

    assign ok = r_right &&
                (r_lcnt != '0) && (r_lcnt < fscp_pkg::CNT_W'(fscp_pkg::FIELD_CHARS)) &&
                (r_cnt != '0) && (r_cnt < fscp_pkg::CNT_W'(fscp_pkg::FIELD_CHARS)) &&
                (r_lmag <= fscp_pkg::MAG_W'(fscp_pkg::SPEED_MAX)) &&
                (r_mag <= fscp_pkg::MAG_W'(fscp_pkg::SPEED_MAX));
    assign lmag8 = {1'b0, r_lmag[6:0]};
    assign rmag8 = {1'b0, r_mag[6:0]};

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_idx       = r_idx;
        n_lastpos   = r_lastpos;
        n_right     = r_right;
        n_first     = r_first;
        n_cphase    = r_cphase;
        n_neg       = r_neg;
        n_mag       = r_mag;
        n_cnt       = r_cnt;
        n_lneg      = r_lneg;
        n_lmag      = r_lmag;
        n_lcnt      = r_lcnt;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out_ok    = r_out_ok;
        n_out_left  = r_out_left;
        n_out_right = r_out_right;
        w_en        = 1'b0;
        w_addr      = r_fill[fscp_pkg::IDX_W-1:0];
        feed        = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_rx.rx_byte == fscp_pkg::CH_START) begin
                        w_en   = 1'b1;
                        w_addr = '0;
                        n_fill = fscp_pkg::FILL_W'(1);
                    end else if (r_fill == '0) begin
                        n_fill = r_fill;
                    end else if (r_fill == fscp_pkg::FILL_W'(fscp_pkg::FRAME_DEPTH)) begin
                        // A full frame ends without a result.
                        n_fill = '0;
                    end else begin
                        w_en = 1'b1;
                        if (i_rx.rx_byte == fscp_pkg::CH_END) begin
                            n_fill    = '0;
                            n_lastpos = r_fill[fscp_pkg::IDX_W-1:0] -
                                        fscp_pkg::IDX_W'(1);
                            n_idx     = fscp_pkg::IDX_W'(1);
                            n_right   = 1'b0;
                            n_first   = 1'b0;
                            n_cphase  = CP_BLANK;
                            n_neg     = 1'b0;
                            n_mag     = '0;
                            n_cnt     = '0;
                            if (r_fill < fscp_pkg::FILL_W'(fscp_pkg::MIN_FRAME - 1)) begin
                                n_state = ST_FIN;
                            end else begin
                                n_state = ST_RD;
                            end
                        end else begin
                            n_fill = r_fill + fscp_pkg::FILL_W'(1);
                        end
                    end
                end
            end
            ST_RD: begin
                n_state = ST_EV;
            end
            ST_EV: begin
                if (!r_right) begin
                    if (r_rdata == fscp_pkg::CH_COMMA) begin
                        // The first comma splits the fields; save the left value.
                        n_right  = 1'b1;
                        n_first  = 1'b1;
                        n_lneg   = r_neg;
                        n_lmag   = r_mag;
                        n_lcnt   = r_cnt;
                        n_cphase = CP_BLANK;
                        n_neg    = 1'b0;
                        n_mag    = '0;
                        n_cnt    = '0;
                    end else if (!((r_idx == fscp_pkg::IDX_W'(1)) &&
                                   (r_rdata == fscp_pkg::CH_LEFT))) begin
                        feed = 1'b1;
                    end
                end else begin
                    n_first = 1'b0;
                    if (!(r_first && (r_rdata == fscp_pkg::CH_RIGHT))) begin
                        feed = 1'b1;
                    end
                end

                if (feed) begin
                    if (r_cnt != fscp_pkg::CNT_W'(fscp_pkg::FIELD_CHARS)) begin
                        n_cnt = r_cnt + fscp_pkg::CNT_W'(1);
                    end
                    case (r_cphase)
                        CP_BLANK: begin
                            if (is_blank) begin
                                n_cphase = CP_BLANK;
                            end else if (r_rdata == fscp_pkg::CH_MINUS) begin
                                n_neg    = 1'b1;
                                n_cphase = CP_DIGIT;
                            end else if (r_rdata == fscp_pkg::CH_PLUS) begin
                                n_cphase = CP_DIGIT;
                            end else if (is_digit) begin
                                n_cphase = CP_DIGIT;
                                n_mag    = (acc > fscp_pkg::ACC_W'(fscp_pkg::MAG_CAP)) ?
                                           fscp_pkg::MAG_W'(fscp_pkg::MAG_CAP) :
                                           acc[fscp_pkg::MAG_W-1:0];
                            end else begin
                                n_cphase = CP_DONE;
                            end
                        end
                        CP_DIGIT: begin
                            if (is_digit) begin
                                n_mag = (acc > fscp_pkg::ACC_W'(fscp_pkg::MAG_CAP)) ?
                                        fscp_pkg::MAG_W'(fscp_pkg::MAG_CAP) :
                                        acc[fscp_pkg::MAG_W-1:0];
                            end else begin
                                n_cphase = CP_DONE;
                            end
                        end
                        default: begin
                            n_cphase = CP_DONE;
                        end
                    endcase
                end

                if (r_idx == r_lastpos) begin
                    n_state = ST_FIN;
                end else begin
                    n_idx   = r_idx + fscp_pkg::IDX_W'(1);
                    n_state = ST_RD;
                end
            end
            ST_FIN: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_out_ok    = ok;
                    n_out_left  = !ok ? 8'd0 : (r_lneg ? (8'd0 - lmag8) : lmag8);
                    n_out_right = !ok ? 8'd0 : (r_neg ? (8'd0 - rmag8) : rmag8);
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            mem[w_addr] <= i_rx.rx_byte;
        end
        if (r_state == ST_RD) begin
            r_rdata <= mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
        r_idx       <= n_idx;
        r_lastpos   <= n_lastpos;
        r_right     <= n_right;
        r_first     <= n_first;
        r_cphase    <= n_cphase;
        r_neg       <= n_neg;
        r_mag       <= n_mag;
        r_cnt       <= n_cnt;
        r_lneg      <= n_lneg;
        r_lmag      <= n_lmag;
        r_lcnt      <= n_lcnt;
        r_out_ok    <= n_out_ok;
        r_out_left  <= n_out_left;
        r_out_right <= n_out_right;
    end

    `FSCP_ASSERT_NOW(a_fill_bound, i_clk, i_rst_n, 1'b1,
        r_fill <= fscp_pkg::FILL_W'(fscp_pkg::FRAME_DEPTH), "fill count past frame depth")
    `FSCP_ASSERT_NOW(a_scan_bound, i_clk, i_rst_n, r_state == ST_RD,
        r_idx <= r_lastpos, "scan index past last frame byte")
    `FSCP_ASSERT_NEXT(a_end_busy, i_clk, i_rst_n,
        accept && (i_rx.rx_byte == fscp_pkg::CH_END) && (r_fill != '0) &&
        (r_fill != fscp_pkg::FILL_W'(fscp_pkg::FRAME_DEPTH)),
        (r_state != ST_IDLE) && (r_fill == '0), "frame end did not start a check")
    `FSCP_ASSERT_NOW(a_fail_zero, i_clk, i_rst_n, r_out_valid && !r_out_ok,
        (r_out_left == 8'd0) && (r_out_right == 8'd0), "rejected frame with nonzero speed")
    `FSCP_ASSERT_NOW(a_ok_range, i_clk, i_rst_n, r_out_valid && r_out_ok,
        ($signed(r_out_left) >= -8'sd100) && ($signed(r_out_left) <= 8'sd100) &&
        ($signed(r_out_right) >= -8'sd100) && ($signed(r_out_right) <= 8'sd100),
        "accepted speed out of range")

endmodule

`default_nettype wire
